// File: rtl/hkrb_pkg.sv
// Shared types and constants for the boot keyboard report builder.
`timescale 1ns / 1ps

package hkrb_pkg;

	// Number of key slots held, and number of slots shown in the report.
	localparam int KEY_SLOTS    = 6;
	localparam int REPORT_SLOTS = 6;

	typedef logic [1:0] op_t;
	typedef logic [7:0] key_t;

	// Operation codes.
	localparam op_t OP_RELEASE     = 2'd0;
	localparam op_t OP_PRESS       = 2'd1;
	localparam op_t OP_RELEASE_ALL = 2'd2;

	// Modifier usages 0xE0..0xE7 share these upper five bits.
	localparam logic [4:0] MOD_PREFIX = 5'b11100;

endpackage

// File: rtl/hid_keyboard_report_builder_top.sv
// Top level of the boot keyboard report builder: input register, report update, result register.
//
//   channel | handshake              | payload
//   --------+------------------------+---------------------------------------------
//   input   | in_valid / in_stall    | op, key_code
//   output  | out_valid / out_stall  | accepted, modifier_byte, slot_zero..slot_five
//
// One item per cycle unless out_stall holds; each result passes the input and result registers.
// The input register feeds the slot compare and shift logic, which writes the report
// registers and the result flag together, so consecutive items chain without a gap.
// When both registers are full, in_stall follows out_stall in the same cycle.
// Reset clears the modifiers, all slots and both valid flags.
`timescale 1ns / 1ps

module hid_keyboard_report_builder_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  hkrb_pkg::op_t     op,
	input  hkrb_pkg::key_t    key_code,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              accepted,
	output hkrb_pkg::key_t    modifier_byte,
	output hkrb_pkg::key_t    slot_zero,
	output hkrb_pkg::key_t    slot_one,
	output hkrb_pkg::key_t    slot_two,
	output hkrb_pkg::key_t    slot_three,
	output hkrb_pkg::key_t    slot_four,
	output hkrb_pkg::key_t    slot_five
);
	import hkrb_pkg::*;

	// Input register.
	logic valid_s1;
	op_t  op_s1;
	key_t code_s1;

	// Report state; it also serves as the result payload.
	key_t mod_q;
	key_t slots_q [KEY_SLOTS];
	logic accepted_q;
	logic out_valid_q;

	// Update logic.
	logic                 advance;
	logic                 fire;
	logic [KEY_SLOTS-1:0] match;
	logic [KEY_SLOTS-1:0] empty;
	logic [KEY_SLOTS-1:0] keep;
	logic [KEY_SLOTS-1:0] first_empty;
	logic                 seen_match;
	logic                 seen_empty;
	logic                 is_mod;
	key_t                 mod_bit;
	key_t                 slots_up [KEY_SLOTS];
	key_t                 slots_nxt [KEY_SLOTS];
	key_t                 mod_nxt;
	logic                 ok;
	key_t                 rep [REPORT_SLOTS];

	// The result register moves when it is empty or its transfer completes.
	assign advance  = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1   <= op;
			code_s1 <= key_code;
		end
	end

	// Each slot as it would read after a shift down by one place.
	for (genvar g = 0; g < KEY_SLOTS; g++) begin : g_up
		if (g == KEY_SLOTS - 1) begin : g_last
			assign slots_up[g] = '0;
		end else begin : g_mid
			assign slots_up[g] = slots_q[g + 1];
		end
	end

	// Slot compares with prefix flags for the lowest match and lowest empty slot.
	always_comb begin
		seen_match = 1'b0;
		seen_empty = 1'b0;
		for (int j = 0; j < KEY_SLOTS; j++) begin
			match[j]       = (slots_q[j] == code_s1);
			empty[j]       = (slots_q[j] == '0);
			first_empty[j] = empty[j] && !seen_empty;
			seen_match     = seen_match || match[j];
			seen_empty     = seen_empty || empty[j];
			keep[j]        = !seen_match;
		end
	end

	assign is_mod  = (code_s1[7:3] == MOD_PREFIX);
	assign mod_bit = key_t'(1) << code_s1[2:0];

	// Next report and result flag.
	always_comb begin
		mod_nxt = mod_q;
		ok      = 1'b0;
		for (int j = 0; j < KEY_SLOTS; j++) begin
			slots_nxt[j] = slots_q[j];
		end
		case (op_s1)
			OP_RELEASE_ALL: begin
				mod_nxt = '0;
				ok      = 1'b1;
				for (int j = 0; j < KEY_SLOTS; j++) begin
					slots_nxt[j] = '0;
				end
			end
			OP_PRESS: begin
				if (is_mod) begin
					mod_nxt = mod_q | mod_bit;
					ok      = 1'b1;
				end else if (|match) begin
					ok = 1'b1;
				end else if (|empty) begin
					ok = 1'b1;
					for (int j = 0; j < KEY_SLOTS; j++) begin
						if (first_empty[j]) begin
							slots_nxt[j] = code_s1;
						end
					end
				end
			end
			OP_RELEASE: begin
				if (is_mod) begin
					mod_nxt = mod_q & ~mod_bit;
					ok      = 1'b1;
				end else if (|match) begin
					ok = 1'b1;
					for (int j = 0; j < KEY_SLOTS; j++) begin
						slots_nxt[j] = keep[j] ? slots_q[j] : slots_up[j];
					end
				end
			end
			default: begin
				ok = 1'b0;
			end
		endcase
	end

	// Report state and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			accepted_q  <= 1'b0;
			mod_q       <= '0;
			for (int j = 0; j < KEY_SLOTS; j++) begin
				slots_q[j] <= '0;
			end
		end else begin
			if (advance) begin
				out_valid_q <= valid_s1;
			end
			if (fire) begin
				accepted_q <= ok;
				mod_q      <= mod_nxt;
				for (int j = 0; j < KEY_SLOTS; j++) begin
					slots_q[j] <= slots_nxt[j];
				end
			end
		end
	end

	// Report view: slots beyond the held count read as empty.
	for (genvar g = 0; g < REPORT_SLOTS; g++) begin : g_rep
		if (g < KEY_SLOTS) begin : g_held
			assign rep[g] = slots_q[g];
		end else begin : g_none
			assign rep[g] = '0;
		end
	end

	assign out_valid     = out_valid_q;
	assign accepted      = accepted_q;
	assign modifier_byte = mod_q;
	assign slot_zero     = rep[0];
	assign slot_one      = rep[1];
	assign slot_two      = rep[2];
	assign slot_three    = rep[3];
	assign slot_four     = rep[4];
	assign slot_five     = rep[5];

endmodule

// File: rtl/hkrb_checker.sv
// Port-level assertions for the boot keyboard report builder, bound to the top level.
`timescale 1ns / 1ps

module hkrb_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           out_valid,
	input  logic           out_stall,
	input  logic           accepted,
	input  hkrb_pkg::key_t modifier_byte,
	input  hkrb_pkg::key_t slot_zero,
	input  hkrb_pkg::key_t slot_one,
	input  hkrb_pkg::key_t slot_two,
	input  hkrb_pkg::key_t slot_three,
	input  hkrb_pkg::key_t slot_four,
	input  hkrb_pkg::key_t slot_five
);
	import hkrb_pkg::*;

	// A result that is held back stays offered.
	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// A result that is held back keeps its accepted flag, modifier byte, slot zero and slot five.
	a_report_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(accepted) && $stable(modifier_byte)
			&& $stable(slot_zero) && $stable(slot_five))
		else $error("report changed while stalled");

	// Held keys are packed toward slot zero: no key follows an empty slot.
	a_packed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (slot_zero != '0 || slot_one == '0)
			&& (slot_one != '0 || slot_two == '0)
			&& (slot_two != '0 || slot_three == '0)
			&& (slot_three != '0 || slot_four == '0)
			&& (slot_four != '0 || slot_five == '0))
		else $error("key slots are not packed");

	// Modifier usages never land in a key slot.
	a_no_mod_slot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> slot_zero[7:3] != MOD_PREFIX && slot_one[7:3] != MOD_PREFIX
			&& slot_two[7:3] != MOD_PREFIX && slot_three[7:3] != MOD_PREFIX
			&& slot_four[7:3] != MOD_PREFIX && slot_five[7:3] != MOD_PREFIX)
		else $error("modifier usage found in a key slot");

	// A held key appears only once in neighboring slots.
	a_no_dup: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (slot_zero == '0 || slot_zero != slot_one)
			&& (slot_one == '0 || slot_one != slot_two)
			&& (slot_two == '0 || slot_two != slot_three)
			&& (slot_three == '0 || slot_three != slot_four)
			&& (slot_four == '0 || slot_four != slot_five))
		else $error("duplicate key in the report");

endmodule

bind hid_keyboard_report_builder_top hkrb_checker u_hkrb_checker (.*);
